// ===== hdl/egas_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, codes and helpers of the epsilon-greedy action selector.
package egas_pkg;

    localparam int unsigned STATES      = 256;
    localparam int unsigned ACTIONS     = 16;
    localparam int unsigned VALUE_WIDTH = 32;

    localparam int unsigned DEPTH  = STATES * ACTIONS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned ROW_W  = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int unsigned COL_W  = $clog2(ACTIONS);
    localparam int unsigned N_W    = $clog2(ACTIONS + 1);

    localparam int unsigned OP_W       = 2;
    localparam int unsigned STATE_IN_W = 8;
    localparam int unsigned ACTION_W   = 4;
    localparam int unsigned Q_W        = 32;
    localparam int unsigned DRAW_W     = 16;
    localparam int unsigned EPS_W      = 17;
    localparam int unsigned NUM_W      = 5;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 17;

    localparam int unsigned DIV_CNT_W = $clog2(EPS_W + 1);

    localparam logic [EPS_W-1:0] EPS_ONE           = EPS_W'(65536);
    localparam logic [EPS_W-1:0] EPS_RESET         = EPS_W'(9830);
    localparam logic [NUM_W-1:0] NUM_ACTIONS_RESET = NUM_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SELECT = 2'd1,
        OP_PROB   = 2'd2
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EPSILON     = 1'd0,
        CFG_NUM_ACTIONS = 1'd1
    } cfg_addr_t;

    // Reduce an 8-bit index modulo a constant by restoring subtraction
    function automatic logic [7:0] wrap_idx(input logic [7:0] v, input int unsigned m);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (32'(m) << k))
            begin
                r = r - (32'(m) << k);
            end
        end
        return r[7:0];
    endfunction

endpackage

// ===== hdl/egas_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and configuration write.
interface egas_req_if;
    import egas_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              operation;
    logic [STATE_IN_W-1:0]        state_index;
    logic [ACTION_W-1:0]          action_index;
    logic signed [Q_W-1:0]        q_value;
    logic [DRAW_W-1:0]            explore_draw;
    logic [DRAW_W-1:0]            pick_draw;

    modport source (output valid, operation, state_index, action_index, q_value,
                    explore_draw, pick_draw, input ready);
    modport sink   (input valid, operation, state_index, action_index, q_value,
                    explore_draw, pick_draw, output ready);
endinterface

interface egas_rsp_if;
    import egas_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] chosen_action;
    logic                explored;
    logic [EPS_W-1:0]    probability;

    modport source (output valid, chosen_action, explored, probability, input ready);
    modport sink   (input valid, chosen_action, explored, probability, output ready);
endinterface

interface egas_cfg_if;
    import egas_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/egas_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
module egas_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/egas_div.sv =====
`timescale 1ns / 1ps
// Restoring divider giving epsilon over the action count, one quotient bit a cycle.
module egas_div import egas_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [EPS_W-1:0] dividend,
    input  logic [N_W-1:0]   divisor,
    output logic             busy,
    output logic [EPS_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [N_W-1:0]       divisor_reg;
    logic [N_W-1:0]       rem_reg;
    logic [EPS_W-1:0]     quo_reg;
    logic [N_W:0]         trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[EPS_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            divisor_reg <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            step_reg    <= '0;
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? N_W'(trial - {1'b0, divisor_reg}) : N_W'(trial);
            quo_reg  <= {quo_reg[EPS_W-2:0], fits};
            step_reg <= step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(EPS_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/epsilon_greedy_action_select.sv =====
`timescale 1ns / 1ps
// Epsilon-greedy action selector over a table of action values held in one RAM.
//
// One request beat is handled at a time. A write stores one value in S_WRITE
// and then answers from S_DONE; a select that explores goes straight to S_DONE.
// A greedy select scans the first n columns of the row, one RAM read per
// cycle through the single table port, then passes S_TARGET and S_RESOLVE
// before it answers from S_DONE. A probability query scans the row while a
// divider forms epsilon / n one bit per cycle; the result waits in S_PROB
// until the 17-step divider is done. The next request is accepted in the
// cycle after a result is registered, even while that result still waits on the
// response channel. Configuration writes are taken at any time and are meant to
// be issued only while the block is idle. Table entries are undefined until written.
module epsilon_greedy_action_select import egas_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    egas_cfg_if.sink   cfg,
    egas_req_if.sink   req,
    egas_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_TARGET,
        S_RESOLVE,
        S_PROB,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [EPS_W-1:0]              epsilon_reg;
    logic [NUM_W-1:0]              num_actions_reg;
    logic [OP_W-1:0]               op_reg;
    logic [ADDR_W-1:0]             base_reg;
    logic [COL_W-1:0]              col_reg;
    logic [VALUE_WIDTH-1:0]        q_reg;
    logic [DRAW_W-1:0]             pick_reg;
    logic [N_W-1:0]                rd_col_reg;
    logic [COL_W-1:0]              cmp_col_reg;
    logic                          cmp_valid_reg;
    logic signed [VALUE_WIDTH-1:0] best_reg;
    logic [ACTIONS-1:0]            mask_reg;
    logic [N_W-1:0]                count_reg;
    logic [N_W-1:0]                target_reg;
    logic [ACTION_W-1:0]           res_action_reg;
    logic                          res_explored_reg;
    logic [EPS_W-1:0]              res_prob_reg;
    logic                          rsp_valid_reg;
    logic [ACTION_W-1:0]           rsp_action_reg;
    logic                          rsp_explored_reg;
    logic [EPS_W-1:0]              rsp_prob_reg;

    logic [EPS_W-1:0]              eps_eff;
    logic [N_W-1:0]                n_eff;
    logic                          req_fire;
    logic [ROW_W-1:0]              req_row;
    logic [COL_W-1:0]              req_col;
    logic                          explore_hit;
    logic                          explore_sel;
    logic [DRAW_W+N_W-1:0]         explore_prod;
    logic [DRAW_W+N_W-1:0]         target_prod;
    logic                          rd_issue;
    logic                          scan_last;
    logic signed [VALUE_WIDTH-1:0] key;
    logic [COL_W-1:0]              resolved_col;
    logic                          is_max;
    logic [EPS_W-1:0]              share;
    logic                          div_busy;
    logic                          div_start;
    logic                          rsp_load;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [VALUE_WIDTH-1:0]        ram_rdata;

    assign eps_eff = (epsilon_reg > EPS_ONE) ? EPS_ONE : epsilon_reg;

    always_comb
    begin
        if (num_actions_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (32'(num_actions_reg) > ACTIONS)
        begin
            n_eff = N_W'(ACTIONS);
        end
        else
        begin
            n_eff = N_W'(num_actions_reg);
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign req_row      = ROW_W'(wrap_idx(req.state_index, STATES));
    assign req_col      = COL_W'(wrap_idx(8'(req.action_index), ACTIONS));
    assign explore_hit  = {1'b0, req.explore_draw} < eps_eff;
    assign explore_sel  = (req.operation == OP_SELECT) && explore_hit;
    assign explore_prod = {{N_W{1'b0}}, req.pick_draw} * {{DRAW_W{1'b0}}, n_eff};
    assign target_prod  = {{N_W{1'b0}}, pick_reg} * {{DRAW_W{1'b0}}, count_reg};
    assign div_start    = req_fire && (req.operation == OP_PROB);
    assign rsp_load     = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    assign rd_issue  = (state_reg == S_SCAN) && (rd_col_reg < n_eff);
    assign scan_last = cmp_valid_reg && ((N_W'(cmp_col_reg) + N_W'(1)) == n_eff);
    assign key       = $signed(ram_rdata);

    assign ram_we   = (state_reg == S_WRITE);
    assign ram_addr = ram_we ? (base_reg + ADDR_W'(col_reg))
                             : (base_reg + ADDR_W'(rd_col_reg));

    always_comb
    begin
        resolved_col = '0;
        for (int i = 0; i < ACTIONS; i++)
        begin
            if (mask_reg[i] &&
                (N_W'($countones(mask_reg & ((ACTIONS'(1) << i) - ACTIONS'(1))))
                 == target_reg))
            begin
                resolved_col = COL_W'(i);
            end
        end
    end

    assign is_max = (N_W'(col_reg) < n_eff) && mask_reg[col_reg];

    egas_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (q_reg),
        .rdata (ram_rdata)
    );

    egas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (eps_eff),
        .divisor  (n_eff),
        .busy     (div_busy),
        .quotient (share)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            epsilon_reg      <= EPS_RESET;
            num_actions_reg  <= NUM_ACTIONS_RESET;
            op_reg           <= '0;
            base_reg         <= '0;
            col_reg          <= '0;
            q_reg            <= '0;
            pick_reg         <= '0;
            rd_col_reg       <= '0;
            cmp_col_reg      <= '0;
            cmp_valid_reg    <= 1'b0;
            best_reg         <= '0;
            mask_reg         <= '0;
            count_reg        <= '0;
            target_reg       <= '0;
            res_action_reg   <= '0;
            res_explored_reg <= 1'b0;
            res_prob_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            rsp_action_reg   <= '0;
            rsp_explored_reg <= 1'b0;
            rsp_prob_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    CFG_EPSILON:     epsilon_reg     <= EPS_W'(cfg.data);
                    CFG_NUM_ACTIONS: num_actions_reg <= cfg.data[NUM_W-1:0];
                    default:         ;
                endcase
            end

            if (rsp_valid_reg && rsp.ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg           <= req.operation;
                        base_reg         <= ADDR_W'(32'(req_row) * ACTIONS);
                        col_reg          <= req_col;
                        q_reg            <= VALUE_WIDTH'($unsigned(req.q_value));
                        pick_reg         <= req.pick_draw;
                        rd_col_reg       <= '0;
                        cmp_valid_reg    <= 1'b0;
                        res_action_reg   <= explore_sel ?
                            ACTION_W'(explore_prod[DRAW_W+N_W-1:DRAW_W]) : '0;
                        res_explored_reg <= explore_sel;
                        res_prob_reg     <= '0;
                        case (req.operation)
                            OP_WRITE:
                            begin
                                state_reg <= S_WRITE;
                            end
                            OP_SELECT:
                            begin
                                state_reg <= explore_hit ? S_DONE : S_SCAN;
                            end
                            OP_PROB:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end

                S_SCAN:
                begin
                    cmp_valid_reg <= rd_issue;
                    cmp_col_reg   <= COL_W'(rd_col_reg);
                    if (rd_issue)
                    begin
                        rd_col_reg <= rd_col_reg + N_W'(1);
                    end
                    if (cmp_valid_reg)
                    begin
                        if ((cmp_col_reg == '0) || (key > best_reg))
                        begin
                            best_reg  <= key;
                            mask_reg  <= ACTIONS'(1) << cmp_col_reg;
                            count_reg <= N_W'(1);
                        end
                        else if (key == best_reg)
                        begin
                            mask_reg[cmp_col_reg] <= 1'b1;
                            count_reg             <= count_reg + N_W'(1);
                        end
                    end
                    if (scan_last)
                    begin
                        state_reg <= (op_reg == OP_SELECT) ? S_TARGET : S_PROB;
                    end
                end

                S_TARGET:
                begin
                    target_reg <= target_prod[DRAW_W+N_W-1:DRAW_W];
                    state_reg  <= S_RESOLVE;
                end

                S_RESOLVE:
                begin
                    res_action_reg <= ACTION_W'(resolved_col);
                    state_reg      <= S_DONE;
                end

                S_PROB:
                begin
                    if (!div_busy)
                    begin
                        res_prob_reg <= is_max ? (EPS_ONE - eps_eff + share) : share;
                        state_reg    <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_action_reg   <= res_action_reg;
                        rsp_explored_reg <= res_explored_reg;
                        rsp_prob_reg     <= res_prob_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.chosen_action = rsp_action_reg;
    assign rsp.explored      = rsp_explored_reg;
    assign rsp.probability   = rsp_prob_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("accepted request beat did not start work");

    a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESOLVE) |-> (target_reg < count_reg))
        else $error("tie target beyond count of maximal actions");

    a_prob_has_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROB) |-> (mask_reg != '0))
        else $error("probability stage reached with empty maximum mask");

    a_prob_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_prob_reg <= EPS_ONE))
        else $error("probability above one");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("table written during row scan");

endmodule
